// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== sv/lpr_pkg.sv =====
// Shared constants, state encoding and control struct for the LRU page replacement block.
package lpr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 20;
  localparam int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int RANK_W    = SLOT_W;
  localparam int FC_W      = 4;
  localparam int FAULT_W   = 16;

  localparam logic [FC_W-1:0]    FC_RESET  = FC_W'(8);
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // Controller states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_SEL  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the accepted reference
    logic compare;  // tag compare against all frames
    logic choose;   // pick hit, empty or victim frame
    logic commit;   // update frames, ranks, count; emit result
  } cmd_t;

endpackage

// ===== sv/lru_page_replacement.sv =====
// Top level of the fully associative LRU page replacement unit.
// Each accepted reference (start high while busy is low) goes through tag compare, frame
// selection, then update of tags, recency ranks and fault count, in the order set by the
// controller sequence. busy stays high from acceptance through the update; the result beat
// shows on out_* with out_valid for exactly one cycle, the first cycle with busy low again,
// so a new reference is accepted only once the last one is through. The receiver cannot
// stall and must take every beat. Writing frame_count (cfg_we, only while idle) flushes all
// frames and the fault count; last_in_sequence flushes them after its own result.

module lru_page_replacement (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [lpr_pkg::PAGE_BITS-1:0]    in_page_number,
  input  logic                             in_last_in_sequence,
  input  logic                             cfg_we,
  input  logic [lpr_pkg::FC_W-1:0]         cfg_wdata,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [lpr_pkg::SLOT_W-1:0]       out_frame_slot,
  output logic                             out_evicted_valid,
  output logic [lpr_pkg::PAGE_BITS-1:0]    out_evicted_page,
  output logic [lpr_pkg::FAULT_W-1:0]      out_fault_count
);

  lpr_pkg::cmd_t cmd;

  lpr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  lpr_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_page_number      (in_page_number),
    .in_last_in_sequence (in_last_in_sequence),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_frame_slot      (out_frame_slot),
    .out_evicted_valid   (out_evicted_valid),
    .out_evicted_page    (out_evicted_page),
    .out_fault_count     (out_fault_count)
  );

endmodule

// ===== sv/lpr_ctrl.sv =====
// Controller state machine sequencing lookup, selection and update of one reference.
`include "assert_macros.svh"

module lpr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output lpr_pkg::cmd_t cmd
);

  lpr_pkg::state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpr_pkg::ST_IDLE: if (start) state_nxt = lpr_pkg::ST_LOOK;
      lpr_pkg::ST_LOOK: state_nxt = lpr_pkg::ST_SEL;
      lpr_pkg::ST_SEL:  state_nxt = lpr_pkg::ST_UPD;
      lpr_pkg::ST_UPD:  state_nxt = lpr_pkg::ST_IDLE;
      default:          state_nxt = lpr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands and status
  assign busy        = (state_r != lpr_pkg::ST_IDLE);
  assign cmd.capture = (state_r == lpr_pkg::ST_IDLE) && start;
  assign cmd.compare = (state_r == lpr_pkg::ST_LOOK);
  assign cmd.choose  = (state_r == lpr_pkg::ST_SEL);
  assign cmd.commit  = (state_r == lpr_pkg::ST_UPD);

  `ASSERT_PROP(a_state_onehot, clk, rst_n, $onehot(state_r), "controller state not one-hot")
  `ASSERT_PROP(a_upd_to_idle, clk, rst_n, cmd.commit |=> !busy, "no return to idle after update")
  `ASSERT_PROP(a_seq_order, clk, rst_n, cmd.capture |=> cmd.compare ##1 cmd.choose ##1 cmd.commit,
    "lookup sequence broken")

endmodule

// ===== sv/lpr_dp.sv =====
// Datapath: frame tags, valid bits, recency ranks, fault counter and result registers.
`include "assert_macros.svh"

module lpr_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lpr_pkg::cmd_t                    cmd,
  input  logic [lpr_pkg::PAGE_BITS-1:0]    in_page_number,
  input  logic                             in_last_in_sequence,
  input  logic                             cfg_we,
  input  logic [lpr_pkg::FC_W-1:0]         cfg_wdata,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [lpr_pkg::SLOT_W-1:0]       out_frame_slot,
  output logic                             out_evicted_valid,
  output logic [lpr_pkg::PAGE_BITS-1:0]    out_evicted_page,
  output logic [lpr_pkg::FAULT_W-1:0]      out_fault_count
);

  localparam int F  = lpr_pkg::FRAMES;
  localparam int SW = lpr_pkg::SLOT_W;
  localparam int RW = lpr_pkg::RANK_W;
  localparam int PW = lpr_pkg::PAGE_BITS;
  localparam int CW = lpr_pkg::FC_W;
  localparam int FW = lpr_pkg::FAULT_W;

  // Lowest set bit of a frame vector
  function automatic logic [SW-1:0] first_idx(input logic [F-1:0] v);
    logic [SW-1:0] idx;
    idx = '0;
    for (int i = F - 1; i >= 0; i--) begin
      if (v[i]) idx = SW'(i);
    end
    return idx;
  endfunction

  // Frame state
  logic [PW-1:0]  frame_page_r [F];
  logic [F-1:0]   valid_r;
  logic [RW-1:0]  rank_r [F];
  logic [FW-1:0]  faults_r;
  logic [CW-1:0]  fc_r;

  // Per-reference pipeline registers
  logic [PW-1:0]  page_r;
  logic           last_r;
  logic [F-1:0]   match_r, empty_r;
  logic [SW-1:0]  slot_r;
  logic           hit_r, evict_r, fill_r;
  logic [RW-1:0]  lim_r;
  logic [PW-1:0]  old_page_r;

  // Result registers
  logic           out_valid_r, out_hit_r, out_evict_r;
  logic [SW-1:0]  out_slot_r;
  logic [PW-1:0]  out_old_r;
  logic [FW-1:0]  out_faults_r;

  // Frames in use: zero counts as one, clamp at the frame total
  logic [CW-1:0]  n_use;
  logic [F-1:0]   in_use;
  always_comb begin
    if (fc_r == '0) n_use = CW'(1);
    else if (fc_r > CW'(F)) n_use = CW'(F);
    else n_use = fc_r;
    for (int i = 0; i < F; i++) in_use[i] = (CW'(i) < n_use);
  end

  // Tag compare against every frame
  logic [F-1:0] match_c, empty_c;
  always_comb begin
    for (int i = 0; i < F; i++) begin
      match_c[i] = in_use[i] && valid_r[i] && (frame_page_r[i] == page_r);
      empty_c[i] = in_use[i] && !valid_r[i];
    end
  end

  // Victim: the in-use frame holding the oldest rank (frames in use minus one)
  logic [F-1:0]  oldest_c;
  logic [RW-1:0] oldest_rank;
  assign oldest_rank = RW'(n_use - CW'(1));
  always_comb begin
    for (int i = 0; i < F; i++) oldest_c[i] = in_use[i] && (rank_r[i] == oldest_rank);
  end

  // Slot choice
  logic          hit_c, any_empty_c;
  logic [SW-1:0] slot_c;
  assign hit_c       = |match_r;
  assign any_empty_c = |empty_r;
  always_comb begin
    if (hit_c) slot_c = first_idx(match_r);
    else if (any_empty_c) slot_c = first_idx(empty_r);
    else slot_c = first_idx(oldest_c);
  end

  // Fault counter next value, saturating
  logic [FW-1:0] faults_inc;
  assign faults_inc = (!hit_r && (faults_r != lpr_pkg::FAULT_MAX)) ? faults_r + FW'(1) : faults_r;

  // Reference capture and stage registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r <= in_page_number;
      last_r <= in_last_in_sequence;
    end
    if (cmd.compare) begin
      match_r <= match_c;
      empty_r <= empty_c;
    end
    if (cmd.choose) begin
      slot_r     <= slot_c;
      hit_r      <= hit_c;
      evict_r    <= !hit_c && !any_empty_c;
      fill_r     <= !hit_c && any_empty_c;
      lim_r      <= rank_r[slot_c];
      old_page_r <= (!hit_c && !any_empty_c) ? frame_page_r[slot_c] : '0;
    end
  end

  // Frame tags have no reset
  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_r) frame_page_r[slot_r] <= page_r;
  end

  // Valid bits, ranks, fault count and frame count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r     <= lpr_pkg::FC_RESET;
      valid_r  <= '0;
      faults_r <= '0;
      for (int i = 0; i < F; i++) rank_r[i] <= '0;
    end else if (cfg_we) begin
      fc_r     <= cfg_wdata;
      valid_r  <= '0;
      faults_r <= '0;
      for (int i = 0; i < F; i++) rank_r[i] <= '0;
    end else if (cmd.commit) begin
      if (last_r) begin
        valid_r  <= '0;
        faults_r <= '0;
        for (int i = 0; i < F; i++) rank_r[i] <= '0;
      end else begin
        valid_r[slot_r] <= 1'b1;
        faults_r        <= faults_inc;
        // Touched frame becomes newest; younger valid frames age by one
        for (int i = 0; i < F; i++) begin
          if (SW'(i) == slot_r) begin
            rank_r[i] <= '0;
          end else if (valid_r[i] && (fill_r || (rank_r[i] < lim_r))) begin
            rank_r[i] <= rank_r[i] + RW'(1);
          end
        end
      end
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
    end
    if (cmd.commit) begin
      out_hit_r    <= hit_r;
      out_slot_r   <= slot_r;
      out_evict_r  <= evict_r;
      out_old_r    <= old_page_r;
      out_faults_r <= faults_inc;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_frame_slot    = out_slot_r;
  assign out_evicted_valid = out_evict_r;
  assign out_evicted_page  = out_old_r;
  assign out_fault_count   = out_faults_r;

  `ASSERT_PROP(a_valid_in_use, clk, rst_n, (valid_r & ~in_use) == '0,
    "valid frame outside frames in use")
  `ASSERT_NEVER(a_hit_evict, clk, rst_n, out_valid && out_hit && out_evicted_valid,
    "hit reported together with eviction")
  `ASSERT_PROP(a_evict_full, clk, rst_n, (cmd.commit && evict_r) |-> ((valid_r | ~in_use) == '1),
    "eviction while an empty frame is in use")

endmodule

// ===== verif/tb_lru_page_replacement.sv =====
// Self-checking testbench for the LRU page replacement unit: driver, predictor and result checker.
module tb_lru_page_replacement;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                         FRAMES    = lpr_pkg::FRAMES;
  localparam int                         PAGE_BITS = lpr_pkg::PAGE_BITS;
  localparam int                         SLOT_W    = lpr_pkg::SLOT_W;
  localparam int                         FC_W      = lpr_pkg::FC_W;
  localparam int                         FAULT_W   = lpr_pkg::FAULT_W;
  localparam logic [FC_W-1:0]            FC_RESET  = lpr_pkg::FC_RESET;
  localparam logic [FAULT_W-1:0]         FAULT_MAX = lpr_pkg::FAULT_MAX;

  localparam int          CLK_PERIOD     = 10;
  localparam int          RESET_CYCLES   = 7;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 10;
  localparam int          MAX_REPORTS    = 10;
  localparam int          PHASE_REFS     = 295;
  // distinct pages through a single frame: every reference faults, each after the first evicts
  localparam int          ONE_FRAME_REFS = 24;
  localparam int unsigned RANK_NONE      = 32'hFFFF_FFFF;

  // what one lookup reports
  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_page;
    logic [FAULT_W-1:0]   faults;
  } lookup_t;

  // work queued for the driver: a page reference, a frame_count write, or a wait for quiet
  typedef enum logic [1:0] {K_REF, K_CFG, K_DRAIN} req_kind_t;

  typedef struct {
    req_kind_t            kind;
    logic [PAGE_BITS-1:0] page;
    logic                 last;
    logic [FC_W-1:0]      fc;
    int unsigned          idle_pct;
  } req_entry_t;

  logic                 clk                 = 1'b0;
  logic                 rst_n               = 1'b0;
  logic                 start               = 1'b0;
  logic                 busy;
  logic [PAGE_BITS-1:0] in_page_number      = '0;
  logic                 in_last_in_sequence = 1'b0;
  logic                 cfg_we              = 1'b0;
  logic [FC_W-1:0]      cfg_wdata           = '0;
  logic                 out_valid;
  logic                 out_hit;
  logic [SLOT_W-1:0]    out_frame_slot;
  logic                 out_evicted_valid;
  logic [PAGE_BITS-1:0] out_evicted_page;
  logic [FAULT_W-1:0]   out_fault_count;

  req_entry_t req_queue[$];
  lookup_t    expected_lookups[$];

  int unsigned issued_cnt    = 0;
  int unsigned delivered_cnt = 0;
  int unsigned fail_cnt      = 0;
  int unsigned idle_cycles   = 0;
  int unsigned hit_cnt       = 0;
  int unsigned evict_cnt     = 0;
  int unsigned peak_faults   = 0;
  logic [15:0] fc_written    = '0;

  // predictor copy of the frame table
  logic [PAGE_BITS-1:0] lru_page  [FRAMES];
  logic                 lru_valid [FRAMES];
  int unsigned          lru_rank  [FRAMES];
  logic [FAULT_W-1:0]   lru_faults;
  logic [FC_W-1:0]      lru_fc;

  lru_page_replacement u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_page_number      (in_page_number),
    .in_last_in_sequence (in_last_in_sequence),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_frame_slot      (out_frame_slot),
    .out_evicted_valid   (out_evicted_valid),
    .out_evicted_page    (out_evicted_page),
    .out_fault_count     (out_fault_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void flush_frames();
    for (int i = 0; i < FRAMES; i++) begin
      lru_page[i]  = '0;
      lru_valid[i] = 1'b0;
      lru_rank[i]  = 0;
    end
    lru_faults = '0;
  endfunction

  // frame s becomes most recent; valid frames younger than limit age by one
  function automatic void age_frames(input int unsigned s, input int unsigned limit);
    for (int i = 0; i < FRAMES; i++) begin
      if (i != s && lru_valid[i] && lru_rank[i] < limit) lru_rank[i]++;
    end
    lru_rank[s] = 0;
  endfunction

  function automatic lookup_t predict_lookup(input logic [PAGE_BITS-1:0] page, input logic last);
    lookup_t     r;
    int unsigned n;
    int unsigned slot;
    int unsigned oldest;
    bit          hit;
    bit          found;
    // zero means one frame, anything above FRAMES saturates
    n     = (lru_fc == 0) ? 1 : ((lru_fc > FRAMES) ? FRAMES : lru_fc);
    r     = '0;
    hit   = 1'b0;
    found = 1'b0;
    slot  = 0;
    for (int i = 0; i < n; i++) begin
      if (!hit && lru_valid[i] && lru_page[i] == page) begin
        slot = i;
        hit  = 1'b1;
      end
    end
    if (hit) begin
      age_frames(slot, lru_rank[slot]);
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!found && !lru_valid[i]) begin
          slot  = i;
          found = 1'b1;
        end
      end
      if (found) begin
        age_frames(slot, RANK_NONE);
        lru_valid[slot] = 1'b1;
        lru_page[slot]  = page;
      end else begin
        // all frames full: the highest rank is the victim, lowest index on ties
        oldest = 0;
        slot   = 0;
        for (int i = 0; i < n; i++) begin
          if (lru_rank[i] > oldest) begin
            oldest = lru_rank[i];
            slot   = i;
          end
        end
        r.ev_valid = 1'b1;
        r.ev_page  = lru_page[slot];
        age_frames(slot, lru_rank[slot]);
        lru_page[slot] = page;
      end
      if (lru_faults != FAULT_MAX) lru_faults++;
    end
    r.hit    = hit;
    r.slot   = slot[SLOT_W-1:0];
    r.faults = lru_faults;
    if (last) flush_frames();
    return r;
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic void note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic string fmt_lookup(input lookup_t v);
    return $sformatf("hit=%0b slot=%0d evicted=%0b evicted_page=%05h faults=%0d",
                     v.hit, v.slot, v.ev_valid, v.ev_page, v.faults);
  endfunction

  function automatic void push_ref(input logic [PAGE_BITS-1:0] page, input logic last,
                                   input int unsigned idle_pct);
    req_entry_t e;
    e.kind     = K_REF;
    e.page     = page;
    e.last     = last;
    e.fc       = '0;
    e.idle_pct = idle_pct;
    req_queue.push_back(e);
  endfunction

  function automatic void push_cfg(input logic [FC_W-1:0] fc);
    req_entry_t e;
    e.kind     = K_CFG;
    e.page     = '0;
    e.last     = 1'b0;
    e.fc       = fc;
    e.idle_pct = 0;
    req_queue.push_back(e);
  endfunction

  function automatic void push_drain();
    req_entry_t e;
    e.kind     = K_DRAIN;
    e.page     = '0;
    e.last     = 1'b0;
    e.fc       = '0;
    e.idle_pct = 0;
    req_queue.push_back(e);
  endfunction

  // random phase: mostly reference streams over a small working set, some noise
  function automatic void add_phase(input int n_items, input int unsigned idle_pct,
                                    input logic [FC_W-1:0] first_fc);
    logic [PAGE_BITS-1:0] pool [16];
    int                   made;
    int                   len;
    int                   psize;
    bit                   broken;
    push_cfg(first_fc);
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 5) == 0) push_cfg(FC_W'($urandom_range(0, 15)));
      if ($urandom_range(0, 9) < 8) begin
        len    = $urandom_range(4, 40);
        psize  = $urandom_range(1, 12);
        broken = ($urandom_range(0, 4) == 0);
        for (int j = 0; j < psize; j++) begin
          case ($urandom_range(0, 9))
            0:       pool[j] = '0;
            1:       pool[j] = '1;
            default: pool[j] = PAGE_BITS'($urandom);
          endcase
        end
        // a broken stream never marks its end and runs into the next one
        for (int k = 0; k < len; k++) begin
          push_ref(pool[$urandom_range(0, psize - 1)], (k == len - 1) && !broken, idle_pct);
        end
        made += len;
        if ($urandom_range(0, 3) == 0) push_drain();
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          push_ref(PAGE_BITS'($urandom), $urandom_range(0, 19) == 0, idle_pct);
        end
        made += len;
      end
    end
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : drive
    logic                 nxt_start;
    logic                 nxt_we;
    logic [FC_W-1:0]      nxt_wdata;
    logic [PAGE_BITS-1:0] nxt_page;
    logic                 nxt_last;
    bit                   quiet;
    if (rst_n) begin
      nxt_start = start;
      nxt_we    = 1'b0;
      nxt_wdata = cfg_wdata;
      nxt_page  = in_page_number;
      nxt_last  = in_last_in_sequence;
      // beat taken at this edge
      if (start && !busy) begin
        expected_lookups.push_back(predict_lookup(in_page_number, in_last_in_sequence));
        issued_cnt++;
        void'(req_queue.pop_front());
        nxt_start = 1'b0;
      end
      quiet = (delivered_cnt >= issued_cnt) && !busy && !start;
      if (!nxt_start && req_queue.size() > 0) begin
        case (req_queue[0].kind)
          K_REF: begin
            if ($urandom_range(0, 99) >= req_queue[0].idle_pct) begin
              nxt_start = 1'b1;
              nxt_page  = req_queue[0].page;
              nxt_last  = req_queue[0].last;
            end
          end
          K_CFG: begin
            if (quiet) begin
              nxt_we                  = 1'b1;
              nxt_wdata               = req_queue[0].fc;
              lru_fc                  = req_queue[0].fc;
              fc_written[lru_fc]      = 1'b1;
              flush_frames();
              void'(req_queue.pop_front());
            end
          end
          K_DRAIN: begin
            if (quiet) void'(req_queue.pop_front());
          end
          default: ;
        endcase
      end
      start               <= nxt_start;
      cfg_we              <= nxt_we;
      cfg_wdata           <= nxt_wdata;
      in_page_number      <= nxt_page;
      in_last_in_sequence <= nxt_last;
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : check
    lookup_t got;
    lookup_t want;
    if (rst_n && out_valid) begin
      got.hit      = out_hit;
      got.slot     = out_frame_slot;
      got.ev_valid = out_evicted_valid;
      got.ev_page  = out_evicted_page;
      got.faults   = out_fault_count;
      delivered_cnt <= delivered_cnt + 1;
      if (got.hit === 1'b1) hit_cnt++;
      if (got.ev_valid === 1'b1) evict_cnt++;
      if (got.faults > peak_faults) peak_faults = got.faults;
      if (expected_lookups.size() == 0) begin
        note_failure({"result beat with nothing pending: ", fmt_lookup(got)});
      end else begin
        want = expected_lookups.pop_front();
        if (got.hit !== want.hit || got.slot !== want.slot ||
            got.ev_valid !== want.ev_valid || got.ev_page !== want.ev_page ||
            got.faults !== want.faults) begin
          note_failure({"mismatch\n  expected ", fmt_lookup(want),
                        "\n  actual   ", fmt_lookup(got)});
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus and end of run

  initial begin
    string fc_list;
    flush_frames();
    lru_fc = FC_RESET;

    // reset frame_count: fill all eight frames, hit, evict, then end the stream on a fault
    push_ref('0, 1'b0, 0);
    push_ref('1, 1'b0, 0);
    push_ref('0, 1'b0, 0);
    for (int p = 1; p <= 6; p++) push_ref(PAGE_BITS'(p), 1'b0, 0);
    push_ref(PAGE_BITS'(7), 1'b0, 0);
    push_ref('1, 1'b1, 0);
    push_drain();
    // frame_count zero behaves as a single frame; the write after it must flush
    push_cfg(FC_W'(0));
    push_ref(PAGE_BITS'(5), 1'b0, 0);
    push_ref(PAGE_BITS'(5), 1'b0, 0);
    push_ref(PAGE_BITS'(9), 1'b0, 0);
    // frame_count above the frame total saturates
    push_cfg(FC_W'(15));
    push_ref(PAGE_BITS'('h55555), 1'b0, 0);
    push_ref(PAGE_BITS'('hAAAAA), 1'b0, 0);
    push_ref(PAGE_BITS'('h55555), 1'b0, 0);
    // one frame, distinct pages back to back
    push_cfg(FC_W'(1));
    for (int k = 0; k < ONE_FRAME_REFS; k++) push_ref(PAGE_BITS'(k), k == ONE_FRAME_REFS - 1, 0);

    add_phase(PHASE_REFS, 0,  FC_W'(8));
    add_phase(PHASE_REFS, 87, FC_W'(2));
    add_phase(PHASE_REFS, 12, FC_W'(9));
    add_phase(PHASE_REFS, 0,  FC_W'($urandom_range(3, 7)));
    add_phase(PHASE_REFS, 87, FC_W'($urandom_range(0, 15)));

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (req_queue.size() != 0 || delivered_cnt < issued_cnt) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_lookups.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", expected_lookups.size()));
    end

    fc_list = "";
    for (int v = 0; v < 16; v++) begin
      if (fc_written[v]) fc_list = {fc_list, $sformatf(" %0d", v)};
    end
    $display("Run: %0d references checked, %0d hits, %0d evictions, peak fault count %0d",
             issued_cnt, hit_cnt, evict_cnt, peak_faults);
    $display("frame_count values written:%s; failures: %0d", fc_list, fail_cnt);

    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lpr_pkg.sv
sv/lpr_ctrl.sv
sv/lpr_dp.sv
sv/lru_page_replacement.sv
verif/tb_lru_page_replacement.sv
